// ===== rtl/bdec_pkg.sv =====
// shared types and constants for the button debouncer with edge counter
`timescale 1ns / 1ps

package bdec_pkg;

	localparam int unsigned TimeW       = 32;
	localparam int unsigned CountW      = 32;
	localparam int unsigned CfgIdxW     = 2;
	localparam int unsigned CfgDataW    = 32;
	localparam int unsigned InDataW     = 40;
	localparam int unsigned InUserW     = 2;
	localparam int unsigned OutDataW    = 40;

	localparam logic [TimeW-1:0] DebounceRst  = TimeW'(50);
	localparam logic [TimeW-1:0] LongPressRst = TimeW'(1000);

	localparam logic [CfgIdxW-1:0] CfgDebounce  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgCountMode = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgLongPress = 2'd2;

	typedef enum logic [1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_FORCE  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CNT_FALL = 2'd0,
		CNT_RISE = 2'd1,
		CNT_BOTH = 2'd2,
		CNT_NONE = 2'd3
	} count_mode_t;

	typedef struct packed {
		logic [TimeW-1:0] debounce_ms;
		count_mode_t      count_mode;
		logic [TimeW-1:0] long_press_ms;
	} cfg_t;

	typedef struct packed {
		mode_t            mode;
		logic             raw_level;
		logic [TimeW-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic              steady_level;
		logic              pressed;
		logic              released;
		logic              long_pressed;
		logic [CountW-1:0] edge_count;
	} result_t;

endpackage

// ===== rtl/bdec_core.sv =====
// debounce state registers and the single-pass update for one beat
`timescale 1ns / 1ps

module bdec_core
	import bdec_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	logic              last_raw_q;
	logic [TimeW-1:0]  last_change_q;
	logic              prev_steady_q;
	logic              cur_steady_q;
	logic [CountW-1:0] edge_count_q;

	logic              last_raw_n;
	logic [TimeW-1:0]  last_change_n;
	logic              prev_steady_n;
	logic              cur_steady_n;
	logic [CountW-1:0] edge_count_n;
	logic [TimeW-1:0]  elapsed;
	logic              fall;
	logic              rise;

	always_comb begin
		last_raw_n    = last_raw_q;
		last_change_n = last_change_q;
		prev_steady_n = prev_steady_q;
		cur_steady_n  = cur_steady_q;
		edge_count_n  = edge_count_q;
		fall          = 1'b0;
		rise          = 1'b0;
		case (item.mode)
			MODE_SAMPLE: begin
				if (item.raw_level != last_raw_q) begin
					last_change_n = item.now_ms;
					last_raw_n    = item.raw_level;
				end
				// settle check against the possibly restarted change time
				if (TimeW'(item.now_ms - last_change_n) >= cfg.debounce_ms) begin
					prev_steady_n = cur_steady_q;
					cur_steady_n  = item.raw_level;
				end
				fall = prev_steady_n & ~cur_steady_n;
				rise = ~prev_steady_n & cur_steady_n;
				if ((cfg.count_mode == CNT_BOTH && (fall || rise)) ||
						(cfg.count_mode == CNT_FALL && fall) ||
						(cfg.count_mode == CNT_RISE && rise)) begin
					edge_count_n = edge_count_q + CountW'(1);
				end
			end
			MODE_CLEAR: begin
				edge_count_n = '0;
			end
			MODE_FORCE: begin
				prev_steady_n = 1'b1;
				cur_steady_n  = 1'b1;
			end
			default: begin
			end
		endcase
		elapsed = item.now_ms - last_change_n;

		res.steady_level = cur_steady_n;
		res.pressed      = prev_steady_n & ~cur_steady_n;
		res.released     = ~prev_steady_n & cur_steady_n;
		res.long_pressed = ~cur_steady_n && (elapsed >= cfg.long_press_ms);
		res.edge_count   = edge_count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= 1'b1;
			last_change_q <= '0;
			prev_steady_q <= 1'b1;
			cur_steady_q  <= 1'b1;
			edge_count_q  <= '0;
		end else if (fire) begin
			last_raw_q    <= last_raw_n;
			last_change_q <= last_change_n;
			prev_steady_q <= prev_steady_n;
			cur_steady_q  <= cur_steady_n;
			edge_count_q  <= edge_count_n;
		end
	end

endmodule

// ===== rtl/button_debounce_edge_counter.sv =====
// top level: stream ports, config registers, input and result registers
//
// channel  dir  fields (lsb first)                               handshake
// s_*      in   tuser: mode[1:0]; tdata: raw_level, now_ms[31:0]  tvalid/tready
// m_*      out  tdata: steady_level, pressed, released,            tvalid/tready
//               long_pressed, edge_count[31:0]
// cfg_*    in   cfg_index[1:0], cfg_data[31:0]                    cfg_we
//
// one beat per cycle sustained while m_tready is high; a taken beat goes into the
// input register, then through the update logic into the result register, which
// drives m_*; a stall on m_* holds the beat in the input register
// arst_n clears valids, debounce state and config to their reset values
// while the result register is held, the input register can still fill;
// s_tready drops only when both stages hold beats and m_tready is low
`timescale 1ns / 1ps

module button_debounce_edge_counter
	import bdec_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,  // raw_level, now_ms[31:0], zero pad
	input  logic [InUserW-1:0]  s_tuser,  // mode[1:0]

	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,  // steady_level, pressed, released,
	                                      // long_pressed, edge_count[31:0], zero pad

	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t    cfg_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res;
	logic    adv_s1;

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DebounceRst;
			cfg_q.count_mode    <= CNT_FALL;
			cfg_q.long_press_ms <= LongPressRst;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgDebounce:  cfg_q.debounce_ms   <= cfg_data[TimeW-1:0];
				CfgCountMode: cfg_q.count_mode    <= count_mode_t'(cfg_data[1:0]);
				CfgLongPress: cfg_q.long_press_ms <= cfg_data[TimeW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.mode      <= mode_t'(s_tuser[1:0]);
			item_s1.raw_level <= s_tdata[0];
			item_s1.now_ms    <= s_tdata[TimeW:1];
		end
	end

	bdec_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OutDataW - 4 - CountW){1'b0}}, res_s2.edge_count,
		res_s2.long_pressed, res_s2.released, res_s2.pressed, res_s2.steady_level};

endmodule

// ===== rtl/bdec_checker.sv =====
// port-level checks for the debouncer, bound to the top level
`timescale 1ns / 1ps

module bdec_checker
	import bdec_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata
);

	// a beat taken is always followed by a result on m_tvalid
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("taken beat produced no result");

	// a free output side never backs up the input side
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output ready");

	// edge flags agree with the steady level they report
	a_flags_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[1] && m_tdata[0]) && !(m_tdata[2] && !m_tdata[0])
			&& !(m_tdata[3] && m_tdata[0]))
		else $error("result flags inconsistent with steady level");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind button_debounce_edge_counter bdec_checker u_bdec_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== bench/testbench.sv =====
// testbench for the button debouncer with edge counter: stream driving and result checking
`timescale 1ns / 1ps

module testbench;
	import bdec_pkg::*;

	localparam logic [1:0] ModeUnused = 2'd3;
	localparam int unsigned CycleLimit = 500000;
	localparam int unsigned PhaseItems = 150;

	// predicts the debouncer per accepted beat and checks results in order
	class debounce_scoreboard;
		logic [TimeW-1:0]  debounce_ms;
		logic [TimeW-1:0]  long_press_ms;
		count_mode_t       cnt_mode;
		logic              last_raw;
		logic [TimeW-1:0]  change_ms;
		logic              prev_lvl;
		logic              cur_lvl;
		logic [CountW-1:0] edges;
		result_t           expected_q[$];
		int                errors;

		function new();
			debounce_ms   = DebounceRst;
			long_press_ms = LongPressRst;
			cnt_mode      = CNT_FALL;
			last_raw      = 1'b1;
			change_ms     = '0;
			prev_lvl      = 1'b1;
			cur_lvl       = 1'b1;
			edges         = '0;
			errors        = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
			case (idx)
				CfgDebounce:  debounce_ms   = val;
				CfgCountMode: cnt_mode      = count_mode_t'(val[1:0]);
				CfgLongPress: long_press_ms = val;
				default: ;
			endcase
		endfunction

		function void note_input(logic [1:0] mode, logic raw, logic [TimeW-1:0] now);
			result_t          res;
			logic [TimeW-1:0] elapsed;
			logic             fall;
			logic             rise;
			if (mode == MODE_SAMPLE) begin
				if (raw != last_raw) begin
					change_ms = now;
					last_raw  = raw;
				end
				elapsed = now - change_ms;
				if (elapsed >= debounce_ms) begin
					prev_lvl = cur_lvl;
					cur_lvl  = raw;
				end
				// edge persists until the next shift, so it keeps counting
				fall = prev_lvl && !cur_lvl;
				rise = !prev_lvl && cur_lvl;
				if ((cnt_mode == CNT_BOTH && (fall || rise)) ||
				    (cnt_mode == CNT_FALL && fall) ||
				    (cnt_mode == CNT_RISE && rise))
					edges = edges + 1'b1;
			end else if (mode == MODE_CLEAR) begin
				edges = '0;
			end else if (mode == MODE_FORCE) begin
				prev_lvl = 1'b1;
				cur_lvl  = 1'b1;
			end
			elapsed          = now - change_ms;
			res.steady_level = cur_lvl;
			res.pressed      = prev_lvl && !cur_lvl;
			res.released     = !prev_lvl && cur_lvl;
			res.long_pressed = !cur_lvl && (elapsed >= long_press_ms);
			res.edge_count   = edges;
			expected_q.push_back(res);
		endfunction

		function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(logic [OutDataW-1:0] data);
			result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("result beat with no expectation waiting: %h", data);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			compare_field("steady_level", 32'(exp_r.steady_level), 32'(data[0]));
			compare_field("pressed", 32'(exp_r.pressed), 32'(data[1]));
			compare_field("released", 32'(exp_r.released), 32'(data[2]));
			compare_field("long_pressed", 32'(exp_r.long_pressed), 32'(data[3]));
			compare_field("edge_count", exp_r.edge_count, data[35:4]);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic [InUserW-1:0]  s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	debounce_scoreboard sb = new();
	bit                 idle_on;
	int unsigned        cycles;
	logic [TimeW-1:0]   stamp;
	logic               held_lvl;

	button_debounce_edge_counter uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("FAIL button_debounce_edge_counter");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tuser, s_tdata[0], s_tdata[32:1]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	// receiver: ready runs broken by stall bursts while idling is on
	initial begin
		forever begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 14)) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end else begin
				repeat ($urandom_range(1, 20)) begin
					@(negedge clk);
					m_tready <= 1'b1;
				end
			end
		end
	end

	task automatic send_item(logic [1:0] mode, logic raw, logic [TimeW-1:0] now);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 14)) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= InDataW'({now, raw});
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and wait until every expected result has come back
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic set_config(logic [TimeW-1:0] deb, count_mode_t cm, logic [TimeW-1:0] lp);
		write_cfg(CfgDebounce, deb);
		write_cfg(CfgCountMode, CfgDataW'(cm));
		write_cfg(CfgLongPress, lp);
	endtask

	// mostly a bouncing button on a running clock, with commands and noise mixed in
	task automatic random_item();
		int unsigned pick;
		logic        raw;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			send_item(MODE_CLEAR, 1'($urandom), $urandom);
		end else if (pick < 7) begin
			send_item(MODE_FORCE, 1'($urandom), stamp);
		end else if (pick < 9) begin
			send_item(ModeUnused, 1'($urandom), stamp + $urandom_range(0, 100));
		end else if (pick < 12) begin
			send_item(MODE_SAMPLE, 1'($urandom), $urandom);
		end else begin
			if ($urandom_range(0, 3) == 0)
				stamp = stamp + $urandom_range(0, 1500);
			else
				stamp = stamp + $urandom_range(0, 30);
			if ($urandom_range(0, 9) == 0)
				held_lvl = ~held_lvl;
			raw = ($urandom_range(0, 4) == 0) ? ~held_lvl : held_lvl;
			send_item(MODE_SAMPLE, raw, stamp);
		end
	endtask

	initial begin
		idle_on  = 1'b0;
		held_lvl = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: press with bounce, lasting edge, long press, commands, wrap
		send_item(MODE_SAMPLE, 1'b1, 32'd0);
		send_item(MODE_SAMPLE, 1'b0, 32'd10);
		send_item(MODE_SAMPLE, 1'b0, 32'd30);
		send_item(MODE_SAMPLE, 1'b0, 32'd60);
		send_item(MODE_SAMPLE, 1'b1, 32'd65);
		send_item(MODE_SAMPLE, 1'b0, 32'd66);
		send_item(MODE_SAMPLE, 1'b0, 32'd1100);
		send_item(MODE_CLEAR, 1'b1, 32'd1200);
		send_item(ModeUnused, 1'b1, 32'd1300);
		send_item(MODE_FORCE, 1'b0, 32'd1400);
		send_item(MODE_SAMPLE, 1'b1, 32'hFFFF_FFF0);
		send_item(MODE_SAMPLE, 1'b1, 32'h0000_0030);
		send_item(MODE_SAMPLE, 1'b0, 32'hFFFF_FFFF);
		send_item(MODE_SAMPLE, 1'b0, 32'hFFFF_FF00);
		settle();

		set_config(32'd0, CNT_BOTH, 32'd0);
		send_item(MODE_SAMPLE, 1'b0, 32'd5);
		send_item(MODE_SAMPLE, 1'b1, 32'd5);
		send_item(MODE_SAMPLE, 1'b1, 32'd6);
		send_item(MODE_SAMPLE, 1'b0, 32'd7);
		settle();

		set_config(32'hFFFF_FFFF, CNT_NONE, 32'hFFFF_FFFF);
		send_item(MODE_SAMPLE, 1'b1, 32'd100);
		send_item(MODE_SAMPLE, 1'b1, 32'd99);
		send_item(MODE_SAMPLE, 1'b0, 32'd200);
		send_item(MODE_SAMPLE, 1'b0, 32'd199);
		send_item(MODE_FORCE, 1'b0, 32'd198);
		settle();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: set_config(DebounceRst, CNT_RISE, LongPressRst);
				1: set_config(32'd0, CNT_BOTH, 32'd0);
				2: set_config(32'hFFFF_FFFF, CNT_FALL, 32'hFFFF_FFFF);
				3: set_config($urandom_range(0, 100), CNT_NONE, $urandom_range(0, 1500));
				4: set_config($urandom_range(0, 100), CNT_BOTH, $urandom_range(0, 1500));
				5: set_config(32'd1, CNT_RISE, 32'd1);
				6: set_config($urandom_range(0, 100), CNT_FALL, $urandom_range(0, 1500));
				7: set_config($urandom_range(0, 100), count_mode_t'($urandom_range(0, 3)),
				              $urandom_range(0, 1500));
				default: set_config($urandom_range(0, 100), CNT_BOTH, $urandom_range(0, 1500));
			endcase
			// idling everywhere except the last phase
			idle_on = (ph != 8);
			stamp   = (ph % 3 == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4000) : $urandom;
			for (int n = 0; n < PhaseItems; n++)
				random_item();
			settle();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("PASS button_debounce_edge_counter");
		end else begin
			$display("FAIL button_debounce_edge_counter");
		end
		$finish;
	end

endmodule
